FILE: hdl/multibulk_request_parser_defines.svh
// assertion macros for the multi-bulk request parser
`ifndef MULTIBULK_REQUEST_PARSER_DEFINES_SVH
`define MULTIBULK_REQUEST_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define MBRP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MBRP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MBRP_ASSERT_IMP(lbl, ante, cons)
`define MBRP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/mbrp_pkg.sv
package mbrp_pkg;

	localparam int ARG_W  = 24;
	localparam int BULK_W = 31;
	localparam int LINE_W = 21;
	localparam int NUM_W  = 32;
	localparam int CFG_W  = 31;
	localparam int CFG_IDX_W = 2;

	localparam logic [ARG_W-1:0]  DEF_MAX_ARG_COUNT   = ARG_W'(1024 * 1024);
	localparam logic [BULK_W-1:0] DEF_MAX_BULK_LENGTH = BULK_W'(1024 * 1024 * 512);
	localparam logic [LINE_W-1:0] DEF_MAX_LINE_LENGTH = LINE_W'(1024 * 64);

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BULK_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_LENGTH = 2'd2;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_BYTE      = 2'd0;
	localparam kind_t KIND_EMPTY_ARG = 2'd1;
	localparam kind_t KIND_EMPTY_REQ = 2'd2;
	localparam kind_t KIND_ERROR     = 2'd3;

	typedef logic [2:0] err_t;
	localparam err_t ERR_NONE       = 3'd0;
	localparam err_t ERR_COUNT_LONG = 3'd1;
	localparam err_t ERR_BAD_COUNT  = 3'd2;
	localparam err_t ERR_NO_DOLLAR  = 3'd3;
	localparam err_t ERR_BAD_LENGTH = 3'd4;
	localparam err_t ERR_LEN_LONG   = 3'd5;
	localparam err_t ERR_INLINE     = 3'd6;

	localparam logic [0:0] CMD_RESTART = 1'b1;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_COUNT     = 4'd1;
	localparam logic [3:0] PH_ARG_START = 4'd2;
	localparam logic [3:0] PH_LENGTH    = 4'd3;
	localparam logic [3:0] PH_SKIP      = 4'd4;
	localparam logic [3:0] PH_PAYLOAD   = 4'd5;
	localparam logic [3:0] PH_ERROR     = 4'd6;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

endpackage

FILE: hdl/multibulk_request_parser.sv
// multi-bulk request parser
// input channel: in_valid / in_stall with command and data_byte. command set
//   restarts the parser at the start of a request, otherwise data_byte is the
//   next request byte. a restart never produces a result.
// output channel: out_valid / out_stall with kind, payload_byte, argument_end,
//   request_end and error_code. each input transaction gives zero or one result.
// config: cfg_write / cfg_index / cfg_data, write only; index 0 max argument
//   count, 1 max bulk length, 2 max header line length. write only while idle.
// path: an accepted input is captured in the input register, then the parse
//   step loads the result register, which drives out_valid.
// throughput: one byte per cycle unless a stalled result blocks it; the parse
//   state is updated by a single pass of logic between the input and result registers.
// stall: while a result waits under out_stall the input register still takes
//   one more transaction; in_stall rises only when both registers are full.
// reset: limits return to their defaults, the parser waits for a request
//   start and both registers are empty. errors latch until a restart.
`include "multibulk_request_parser_defines.svh"

module multibulk_request_parser
	import mbrp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [7:0]           data_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [7:0]           payload_byte,
	output logic                 argument_end,
	output logic                 request_end,
	output logic [2:0]           error_code,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [ARG_W-1:0]  max_arg_q;
	logic [BULK_W-1:0] max_bulk_q;
	logic [LINE_W-1:0] max_line_q;

	logic       valid_s1;
	logic       command_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic [3:0]        phase_q,   phase_d;
	logic [NUM_W-1:0]  num_q,     num_d;
	logic              neg_q,     neg_d;
	logic              inv_q,     inv_d;
	logic [LINE_W-1:0] line_q,    line_d;
	logic [ARG_W-1:0]  args_q,    args_d;
	logic [BULK_W-1:0] payload_q, payload_d;
	logic [1:0]        skip_q,    skip_d;

	logic       res_valid;
	kind_t      res_kind;
	logic [7:0] res_byte;
	logic       res_aend;
	logic       res_rend;
	err_t       res_code;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       byte_q;
	logic             aend_q;
	logic             rend_q;
	err_t             code_q;

	logic             first_digit;
	logic             is_digit;
	logic [3:0]       digit;
	logic [NUM_W+3:0] prod;
	logic [NUM_W-1:0] num_next;
	logic             num_bad;
	logic [ARG_W-1:0]  args_dec;
	logic [BULK_W-1:0] payload_dec;
	logic [1:0]        skip_dec;

	// the input register only holds when the result register is full and stalled
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_arg_q  <= DEF_MAX_ARG_COUNT;
			max_bulk_q <= DEF_MAX_BULK_LENGTH;
			max_line_q <= DEF_MAX_LINE_LENGTH;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MAX_ARG_COUNT:   max_arg_q  <= cfg_data[ARG_W-1:0];
				CFG_MAX_BULK_LENGTH: max_bulk_q <= cfg_data[BULK_W-1:0];
				CFG_MAX_LINE_LENGTH: max_line_q <= cfg_data[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			byte_s1    <= data_byte;
		end
	end

	// decimal digest helpers
	assign is_digit    = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
	assign digit       = byte_s1[3:0];
	assign first_digit = (line_q == LINE_W'(neg_q));
	assign prod        = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + (NUM_W+4)'(digit);
	assign num_next    = (|prod[NUM_W+3:NUM_W]) ? {NUM_W{1'b1}} : prod[NUM_W-1:0];
	assign num_bad     = inv_q || first_digit;
	assign args_dec    = (args_q != '0) ? args_q - ARG_W'(1) : args_q;
	assign payload_dec = (payload_q != '0) ? payload_q - BULK_W'(1) : payload_q;
	assign skip_dec    = (skip_q != '0) ? skip_q - 2'd1 : skip_q;

	always_comb begin
		phase_d   = phase_q;
		num_d     = num_q;
		neg_d     = neg_q;
		inv_d     = inv_q;
		line_d    = line_q;
		args_d    = args_q;
		payload_d = payload_q;
		skip_d    = skip_q;
		res_valid = 1'b0;
		res_kind  = KIND_BYTE;
		res_byte  = 8'd0;
		res_aend  = 1'b0;
		res_rend  = 1'b0;
		res_code  = ERR_NONE;
		if (command_s1 == CMD_RESTART) begin
			phase_d   = PH_IDLE;
			num_d     = '0;
			neg_d     = 1'b0;
			inv_d     = 1'b0;
			line_d    = '0;
			args_d    = '0;
			payload_d = '0;
			skip_d    = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (byte_s1 != CH_STAR) begin
						phase_d   = PH_ERROR;
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_code  = ERR_INLINE;
					end else begin
						num_d   = '0;
						neg_d   = 1'b0;
						inv_d   = 1'b0;
						line_d  = '0;
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT, PH_LENGTH: begin
					if (byte_s1 != CH_CR) begin
						if (line_q >= max_line_q) begin
							phase_d   = PH_ERROR;
							res_valid = 1'b1;
							res_kind  = KIND_ERROR;
							res_code  = (phase_q == PH_COUNT) ? ERR_COUNT_LONG : ERR_LEN_LONG;
						end else begin
							if (byte_s1 == CH_MINUS) begin
								if (line_q == '0) begin
									neg_d = 1'b1;
								end else begin
									inv_d = 1'b1;
								end
							end else if (is_digit) begin
								if (first_digit) begin
									if (digit == 4'd0 && neg_q) begin
										inv_d = 1'b1;
									end
									num_d = NUM_W'(digit);
								end else begin
									// leading zero
									if (num_q == '0) begin
										inv_d = 1'b1;
									end
									num_d = num_next;
								end
							end else begin
								inv_d = 1'b1;
							end
							line_d = line_q + LINE_W'(1);
						end
					end else if (phase_q == PH_COUNT) begin
						if (num_bad || (!neg_q && num_q > NUM_W'(max_arg_q))) begin
							phase_d   = PH_ERROR;
							res_valid = 1'b1;
							res_kind  = KIND_ERROR;
							res_code  = ERR_BAD_COUNT;
						end else begin
							payload_d = '0;
							skip_d    = 2'd1;
							phase_d   = PH_SKIP;
							if (neg_q || num_q == '0) begin
								args_d    = '0;
								res_valid = 1'b1;
								res_kind  = KIND_EMPTY_REQ;
								res_rend  = 1'b1;
							end else begin
								args_d = num_q[ARG_W-1:0];
							end
						end
					end else begin
						if (num_bad || neg_q || num_q > NUM_W'(max_bulk_q)) begin
							phase_d   = PH_ERROR;
							res_valid = 1'b1;
							res_kind  = KIND_ERROR;
							res_code  = ERR_BAD_LENGTH;
						end else begin
							phase_d = PH_SKIP;
							if (num_q == '0) begin
								args_d    = args_dec;
								payload_d = '0;
								skip_d    = 2'd3;
								res_valid = 1'b1;
								res_kind  = KIND_EMPTY_ARG;
								res_aend  = 1'b1;
								res_rend  = (args_q <= ARG_W'(1));
							end else begin
								payload_d = num_q[BULK_W-1:0];
								skip_d    = 2'd1;
							end
						end
					end
				end
				PH_ARG_START: begin
					if (byte_s1 != CH_DOLLAR) begin
						phase_d   = PH_ERROR;
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_code  = ERR_NO_DOLLAR;
					end else begin
						num_d   = '0;
						neg_d   = 1'b0;
						inv_d   = 1'b0;
						line_d  = '0;
						phase_d = PH_LENGTH;
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						if (payload_q != '0) begin
							phase_d = PH_PAYLOAD;
						end else if (args_q != '0) begin
							phase_d = PH_ARG_START;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end
				PH_PAYLOAD: begin
					payload_d = payload_dec;
					res_valid = 1'b1;
					res_kind  = KIND_BYTE;
					res_byte  = byte_s1;
					if (payload_dec == '0) begin
						args_d   = args_dec;
						skip_d   = 2'd2;
						phase_d  = PH_SKIP;
						res_aend = 1'b1;
						res_rend = (args_dec == '0);
					end
				end
				PH_ERROR: begin
					phase_d = PH_ERROR;
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			num_q     <= '0;
			neg_q     <= 1'b0;
			inv_q     <= 1'b0;
			line_q    <= '0;
			args_q    <= '0;
			payload_q <= '0;
			skip_q    <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			num_q     <= num_d;
			neg_q     <= neg_d;
			inv_q     <= inv_d;
			line_q    <= line_d;
			args_q    <= args_d;
			payload_q <= payload_d;
			skip_q    <= skip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			kind_q <= res_kind;
			byte_q <= res_byte;
			aend_q <= res_aend;
			rend_q <= res_rend;
			code_q <= res_code;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = byte_q;
	assign argument_end = aend_q;
	assign request_end  = rend_q;
	assign error_code   = code_q;

	// a latched error swallows bytes until a restart
	`MBRP_ASSERT_IMP(a_error_silent,
		advance && command_s1 != CMD_RESTART && phase_q == PH_ERROR, !res_valid)
	`MBRP_ASSERT_IMP(a_code_only_on_error,
		out_valid_q && kind_q != KIND_ERROR, code_q == ERR_NONE)
	`MBRP_ASSERT_IMP(a_request_end_marks,
		out_valid_q && rend_q, aend_q || kind_q == KIND_EMPTY_REQ)
	`MBRP_ASSERT_NXT(a_restart_to_idle,
		advance && command_s1 == CMD_RESTART, phase_q == PH_IDLE && args_q == '0)

endmodule
